// ===== sv/itp_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// itp_pkg: shared types, constants and microcode for the infix to postfix
// converter.
// Holds the transfer payload structs, operator codes, the character
// classifier and the control store of the sequencer.
// ============================================================================
package itp_pkg;

    // Operator stack geometry.
    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CODE_W      = 3;

    // Width of a microcode address.
    localparam int UA_W = 5;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_expr;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       is_last;
        logic [1:0] error_code;
    } out_item_t;

    // Stored operator codes.
    typedef enum logic [CODE_W-1:0] {
        OPC_OPEN = 3'd0,
        OPC_POW  = 3'd1,
        OPC_MUL  = 3'd2,
        OPC_DIV  = 3'd3,
        OPC_ADD  = 3'd4,
        OPC_SUB  = 3'd5
    } op_code_t;

    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_OPERAND,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_OPER
    } cls_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNMATCHED = 2'd2
    } err_t;

    // Byte source of a microinstruction.
    typedef enum logic [2:0] {
        EM_NONE,
        EM_CHAR,
        EM_SPACE,
        EM_TOP,
        EM_FINAL
    } emit_t;

    typedef enum logic [1:0] {
        STK_NONE,
        STK_PUSH,
        STK_POP
    } stk_t;

    // Jump conditions. C_NEXT always falls through.
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_INPUT,
        C_CLASS,
        C_NO_POP,
        C_CLOSE_STOP,
        C_NOT_LAST,
        C_EMPTY
    } cond_t;

    typedef struct packed {
        logic             accept;
        logic             set_err;
        emit_t            emit;
        stk_t             stk;
        cond_t            cond;
        logic [UA_W-1:0]  target;
    } ctrl_t;

    // Status the datapath returns to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic hold;
        logic no_pop;
        logic close_stop;
        logic not_last;
        logic empty;
        cls_t cls;
    } flags_t;

    // Microcode entry points.
    localparam logic [UA_W-1:0] UA_IDLE       = 5'd0;
    localparam logic [UA_W-1:0] UA_DISPATCH   = 5'd1;
    localparam logic [UA_W-1:0] UA_OPERAND    = 5'd2;
    localparam logic [UA_W-1:0] UA_OPND_SPACE = 5'd3;
    localparam logic [UA_W-1:0] UA_OP_LOOP    = 5'd4;
    localparam logic [UA_W-1:0] UA_OP_POP     = 5'd5;
    localparam logic [UA_W-1:0] UA_OP_SPACE   = 5'd6;
    localparam logic [UA_W-1:0] UA_PUSH       = 5'd7;
    localparam logic [UA_W-1:0] UA_CLOSE_LOOP = 5'd8;
    localparam logic [UA_W-1:0] UA_CLOSE_POP  = 5'd9;
    localparam logic [UA_W-1:0] UA_CLOSE_SPC  = 5'd10;
    localparam logic [UA_W-1:0] UA_CLOSE_END  = 5'd11;
    localparam logic [UA_W-1:0] UA_END        = 5'd12;
    localparam logic [UA_W-1:0] UA_FLUSH      = 5'd13;
    localparam logic [UA_W-1:0] UA_FLUSH_POP  = 5'd14;
    localparam logic [UA_W-1:0] UA_FLUSH_SPC  = 5'd15;
    localparam logic [UA_W-1:0] UA_FINISH     = 5'd16;

    function automatic cls_t classify(input logic [7:0] ch);
        cls_t c;
        case (ch)
            8'h20:   c = CLS_SPACE;
            8'h28:   c = CLS_OPEN;
            8'h29:   c = CLS_CLOSE;
            8'h5E,
            8'h2A,
            8'h2F,
            8'h2B,
            8'h2D:   c = CLS_OPER;
            default: c = CLS_OPERAND;
        endcase
        return c;
    endfunction

    function automatic op_code_t op_of(input logic [7:0] ch);
        op_code_t o;
        case (ch)
            8'h5E:   o = OPC_POW;
            8'h2A:   o = OPC_MUL;
            8'h2F:   o = OPC_DIV;
            8'h2B:   o = OPC_ADD;
            8'h2D:   o = OPC_SUB;
            default: o = OPC_OPEN;
        endcase
        return o;
    endfunction

    // Smaller binds tighter; an open bracket never pops.
    function automatic logic [3:0] prec(input op_code_t o);
        logic [3:0] p;
        case (o)
            OPC_POW: p = 4'd1;
            OPC_MUL,
            OPC_DIV: p = 4'd2;
            OPC_ADD,
            OPC_SUB: p = 4'd3;
            default: p = 4'd9;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] code_char(input op_code_t o);
        logic [7:0] ch;
        case (o)
            OPC_POW: ch = 8'h5E;
            OPC_MUL: ch = 8'h2A;
            OPC_DIV: ch = 8'h2F;
            OPC_ADD: ch = 8'h2B;
            OPC_SUB: ch = 8'h2D;
            default: ch = 8'h28;
        endcase
        return ch;
    endfunction

    function automatic logic [UA_W-1:0] class_target(input cls_t c);
        logic [UA_W-1:0] t;
        case (c)
            CLS_OPERAND: t = UA_OPERAND;
            CLS_OPEN:    t = UA_PUSH;
            CLS_CLOSE:   t = UA_CLOSE_LOOP;
            CLS_OPER:    t = UA_OP_LOOP;
            default:     t = UA_END;
        endcase
        return t;
    endfunction

    function automatic ctrl_t mw(input logic            accept,
                                 input logic            set_err,
                                 input emit_t           emit,
                                 input stk_t            stk,
                                 input cond_t           cond,
                                 input logic [UA_W-1:0] target);
        ctrl_t w;
        w.accept  = accept;
        w.set_err = set_err;
        w.emit    = emit;
        w.stk     = stk;
        w.cond    = cond;
        w.target  = target;
        return w;
    endfunction

    // Control store.
    function automatic ctrl_t micro_word(input logic [UA_W-1:0] pc);
        ctrl_t w;
        case (pc)
            UA_IDLE:       w = mw(1'b1, 1'b0, EM_NONE,  STK_NONE, C_NO_INPUT,   UA_IDLE);
            UA_DISPATCH:   w = mw(1'b0, 1'b1, EM_NONE,  STK_NONE, C_CLASS,      UA_END);
            UA_OPERAND:    w = mw(1'b0, 1'b0, EM_CHAR,  STK_NONE, C_NEXT,       UA_IDLE);
            UA_OPND_SPACE: w = mw(1'b0, 1'b0, EM_SPACE, STK_NONE, C_ALWAYS,     UA_END);
            UA_OP_LOOP:    w = mw(1'b0, 1'b0, EM_NONE,  STK_NONE, C_NO_POP,     UA_PUSH);
            UA_OP_POP:     w = mw(1'b0, 1'b0, EM_TOP,   STK_POP,  C_NEXT,       UA_IDLE);
            UA_OP_SPACE:   w = mw(1'b0, 1'b0, EM_SPACE, STK_NONE, C_ALWAYS,     UA_OP_LOOP);
            UA_PUSH:       w = mw(1'b0, 1'b0, EM_NONE,  STK_PUSH, C_ALWAYS,     UA_END);
            UA_CLOSE_LOOP: w = mw(1'b0, 1'b0, EM_NONE,  STK_NONE, C_CLOSE_STOP, UA_CLOSE_END);
            UA_CLOSE_POP:  w = mw(1'b0, 1'b0, EM_TOP,   STK_POP,  C_NEXT,       UA_IDLE);
            UA_CLOSE_SPC:  w = mw(1'b0, 1'b0, EM_SPACE, STK_NONE, C_ALWAYS,     UA_CLOSE_LOOP);
            UA_CLOSE_END:  w = mw(1'b0, 1'b0, EM_NONE,  STK_POP,  C_NEXT,       UA_IDLE);
            UA_END:        w = mw(1'b0, 1'b0, EM_NONE,  STK_NONE, C_NOT_LAST,   UA_FINISH);
            UA_FLUSH:      w = mw(1'b0, 1'b0, EM_NONE,  STK_NONE, C_EMPTY,      UA_FINISH);
            UA_FLUSH_POP:  w = mw(1'b0, 1'b0, EM_TOP,   STK_POP,  C_NEXT,       UA_IDLE);
            UA_FLUSH_SPC:  w = mw(1'b0, 1'b0, EM_SPACE, STK_NONE, C_ALWAYS,     UA_FLUSH);
            UA_FINISH:     w = mw(1'b0, 1'b0, EM_FINAL, STK_NONE, C_ALWAYS,     UA_IDLE);
            default:       w = mw(1'b0, 1'b0, EM_NONE,  STK_NONE, C_ALWAYS,     UA_IDLE);
        endcase
        return w;
    endfunction

endpackage

// ===== sv/infix_to_postfix_converter.sv =====
`timescale 1ns / 1ps
// ============================================================================
// infix_to_postfix_converter: shunting-yard conversion of a character stream
// Takes one infix character per transfer and produces the postfix text as a
// byte stream, each token followed by a space.
// ============================================================================
// The block works on one character at a time under a small microprogram. A
// character is taken and classified in an idle step, dispatched on its class
// in a dispatch step, and then handled: an operand emits itself and a space,
// an open bracket is pushed, an operator pops and emits the entries it yields
// to and is then pushed, a close bracket pops and emits entries down to its
// open bracket, which it drops, and the end of an expression flushes the
// stack. An emitted byte that pushes out a staged byte needs the single output
// register to be free, so a stalled output simply holds the sequencer in
// place. One byte is always held back in a staging register so that the final
// byte of an expression can be flagged with is_last, and every byte of a
// character carries that character's error code, known before any byte
// leaves: a close bracket errs when no open bracket is stacked (a running
// count tracks them), an open bracket overflows when the stack is full, and
// an operator only when the stack is full and nothing can be popped. The
// operator stack lives in a small RAM with a registered read port addressed
// at the current top of stack; the microcode leaves at least one step after
// every push or pop before the top is used. Stack entries hold no reset value
// and their contents are used only below the fill count.
module infix_to_postfix_converter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                infix_valid,
    output logic                infix_stall,
    input  itp_pkg::in_item_t   infix_item,
    output logic                postfix_valid,
    input  logic                postfix_stall,
    output itp_pkg::out_item_t  postfix_item
);

    itp_pkg::ctrl_t  ctrl;
    itp_pkg::flags_t flags;

    // Latched character and its decoded form.
    logic [7:0]         char_reg;
    logic [7:0]         char_next;
    logic               last_reg;
    logic               last_next;
    itp_pkg::cls_t      cls_reg;
    itp_pkg::cls_t      cls_next;
    itp_pkg::op_code_t  code_reg;
    itp_pkg::op_code_t  code_next;
    itp_pkg::err_t      err_reg;
    itp_pkg::err_t      err_next;

    // Stack bookkeeping.
    logic [itp_pkg::CNT_W-1:0] cnt_reg;
    logic [itp_pkg::CNT_W-1:0] cnt_next;
    logic [itp_pkg::CNT_W-1:0] open_reg;
    logic [itp_pkg::CNT_W-1:0] open_next;
    logic [itp_pkg::CNT_W-1:0] cnt_dec;

    // Staging byte and output register.
    logic [7:0]          pend_reg;
    logic [7:0]          pend_next;
    logic                pend_valid_reg;
    logic                pend_valid_next;
    itp_pkg::out_item_t  out_reg;
    itp_pkg::out_item_t  out_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    // Stack RAM signals.
    logic                       ram_we;
    logic [itp_pkg::CODE_W-1:0] ram_rdata;
    itp_pkg::op_code_t          top_code;

    logic       accept;
    logic       not_empty;
    logic       full;
    logic       no_pop;
    logic       out_free;
    logic       final_has;
    logic       hold;
    logic       go;
    logic       byte_emit;
    logic [7:0] emit_byte;
    logic       do_push;
    logic       do_pop;

    itp_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    // The read address always follows the current top of stack.
    assign cnt_dec = cnt_reg - itp_pkg::CNT_W'(1);

    itp_ram #(
        .WIDTH (itp_pkg::CODE_W),
        .DEPTH (itp_pkg::STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[itp_pkg::ADDR_W-1:0]),
        .wdata (code_reg),
        .raddr (cnt_dec[itp_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign top_code  = itp_pkg::op_code_t'(ram_rdata);
    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));

    // An operator pops every stacked entry that binds at least as tightly.
    assign no_pop = !(not_empty &&
                      (itp_pkg::prec(top_code) <= itp_pkg::prec(code_reg)));

    // The output register can take a byte when empty or being drained now.
    assign out_free  = !out_valid_reg || !postfix_stall;
    assign final_has = pend_valid_reg || last_reg || (err_reg != itp_pkg::ERR_NONE);

    always_comb
    begin
        byte_emit = 1'b0;
        emit_byte = itp_pkg::CHAR_SPACE;
        hold      = 1'b0;
        case (ctrl.emit)
            itp_pkg::EM_CHAR:
            begin
                byte_emit = 1'b1;
                emit_byte = char_reg;
                hold      = pend_valid_reg && !out_free;
            end
            itp_pkg::EM_SPACE:
            begin
                byte_emit = 1'b1;
                hold      = pend_valid_reg && !out_free;
            end
            itp_pkg::EM_TOP:
            begin
                byte_emit = 1'b1;
                emit_byte = itp_pkg::code_char(top_code);
                hold      = pend_valid_reg && !out_free;
            end
            itp_pkg::EM_FINAL:
            begin
                hold = final_has && !out_free;
            end
            default:
            begin
                hold = 1'b0;
            end
        endcase
    end

    assign go          = !hold;
    assign infix_stall = !ctrl.accept;
    assign accept      = ctrl.accept && infix_valid;
    assign do_push     = go && (ctrl.stk == itp_pkg::STK_PUSH) && (err_reg == itp_pkg::ERR_NONE);
    assign do_pop      = go && (ctrl.stk == itp_pkg::STK_POP) && not_empty;
    assign ram_we      = do_push;

    always_comb
    begin
        flags.in_valid   = infix_valid;
        flags.hold       = hold;
        flags.no_pop     = no_pop;
        flags.close_stop = !not_empty || (top_code == itp_pkg::OPC_OPEN);
        flags.not_last   = !last_reg;
        flags.empty      = !not_empty;
        flags.cls        = cls_reg;
    end

    // Next-state logic for the datapath registers.
    always_comb
    begin
        char_next       = char_reg;
        last_next       = last_reg;
        cls_next        = cls_reg;
        code_next       = code_reg;
        err_next        = err_reg;
        cnt_next        = cnt_reg;
        open_next       = open_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && postfix_stall;

        if (accept)
        begin
            char_next = infix_item.in_char;
            last_next = infix_item.end_of_expr;
            cls_next  = itp_pkg::classify(infix_item.in_char);
            code_next = itp_pkg::op_of(infix_item.in_char);
        end

        // The error code of the character is settled before any byte leaves.
        if (ctrl.set_err)
        begin
            case (cls_reg)
                itp_pkg::CLS_CLOSE:
                    err_next = (open_reg == '0) ? itp_pkg::ERR_UNMATCHED : itp_pkg::ERR_NONE;
                itp_pkg::CLS_OPEN:
                    err_next = full ? itp_pkg::ERR_OVERFLOW : itp_pkg::ERR_NONE;
                itp_pkg::CLS_OPER:
                    err_next = (full && no_pop) ? itp_pkg::ERR_OVERFLOW : itp_pkg::ERR_NONE;
                default:
                    err_next = itp_pkg::ERR_NONE;
            endcase
        end

        if (do_push)
        begin
            cnt_next = cnt_reg + itp_pkg::CNT_W'(1);
            if (code_reg == itp_pkg::OPC_OPEN)
            begin
                open_next = open_reg + itp_pkg::CNT_W'(1);
            end
        end
        else if (do_pop)
        begin
            cnt_next = cnt_dec;
            if (top_code == itp_pkg::OPC_OPEN)
            begin
                open_next = open_reg - itp_pkg::CNT_W'(1);
            end
        end

        // A new byte pushes the staged byte out and takes its place.
        if (byte_emit && go)
        begin
            if (pend_valid_reg)
            begin
                out_next.out_char   = pend_reg;
                out_next.is_last    = 1'b0;
                out_next.error_code = err_reg;
                out_valid_next      = 1'b1;
            end
            pend_next       = emit_byte;
            pend_valid_next = 1'b1;
        end

        // Close the character: release the staged byte, or stand in for it.
        // A character with nothing to send leaves a waiting transfer alone.
        if ((ctrl.emit == itp_pkg::EM_FINAL) && go)
        begin
            if (final_has)
            begin
                out_next.is_last    = last_reg;
                out_next.error_code = err_reg;
                if (pend_valid_reg)
                begin
                    out_next.out_char = pend_reg;
                end
                else if (last_reg)
                begin
                    out_next.out_char = itp_pkg::CHAR_SPACE;
                end
                else
                begin
                    out_next.out_char = itp_pkg::CHAR_NUL;
                end
                out_valid_next = 1'b1;
            end
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            open_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_reg       <= 1'b0;
            err_reg        <= itp_pkg::ERR_NONE;
            cls_reg        <= itp_pkg::CLS_SPACE;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            open_reg       <= open_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            last_reg       <= last_next;
            err_reg        <= err_next;
            cls_reg        <= cls_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        code_reg <= code_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign postfix_valid = out_valid_reg;
    assign postfix_item  = out_reg;

endmodule

// ===== sv/itp_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// itp_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ============================================================================
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/itp_seq.sv =====
`timescale 1ns / 1ps
// ============================================================================
// itp_seq: microcode sequencer
// Step counter over the control store with conditional and dispatch jumps.
// ============================================================================
module itp_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  itp_pkg::flags_t flags,
    output itp_pkg::ctrl_t  ctrl
);

    logic [itp_pkg::UA_W-1:0] pc_reg;
    logic [itp_pkg::UA_W-1:0] pc_next;
    logic [itp_pkg::UA_W-1:0] pc_inc;

    assign ctrl   = itp_pkg::micro_word(pc_reg);
    assign pc_inc = pc_reg + itp_pkg::UA_W'(1);

    always_comb
    begin
        pc_next = pc_reg;
        if (!flags.hold)
        begin
            case (ctrl.cond)
                itp_pkg::C_NEXT:       pc_next = pc_inc;
                itp_pkg::C_ALWAYS:     pc_next = ctrl.target;
                itp_pkg::C_NO_INPUT:   pc_next = flags.in_valid ? pc_inc : ctrl.target;
                itp_pkg::C_CLASS:      pc_next = itp_pkg::class_target(flags.cls);
                itp_pkg::C_NO_POP:     pc_next = flags.no_pop ? ctrl.target : pc_inc;
                itp_pkg::C_CLOSE_STOP: pc_next = flags.close_stop ? ctrl.target : pc_inc;
                itp_pkg::C_NOT_LAST:   pc_next = flags.not_last ? ctrl.target : pc_inc;
                itp_pkg::C_EMPTY:      pc_next = flags.empty ? ctrl.target : pc_inc;
                default:               pc_next = itp_pkg::UA_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= itp_pkg::UA_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule
